FILE: rtl/crec_pkg.sv
// ----------------------------------------------------------------------------
// crec_pkg
// Shared constants, codes and types of the calorimeter hit energy
// reconstruction block.
// ----------------------------------------------------------------------------
package crec_pkg;

  // Number of layers in the layer factor table.
  localparam int NUM_LAYERS = 64;
  localparam int LAYER_ADDR_W = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;

  // Field widths.
  localparam int ID_W     = 32;
  localparam int LAYER_W  = 6;
  localparam int ADC_W    = 10;
  localparam int TOT_W    = 12;
  localparam int TOA_W    = 10;
  localparam int GAIN_W   = 16;
  localparam int VOLT_W   = 24;
  localparam int SCALE_W  = 24;
  localparam int FACTOR_W = 24;
  localparam int PERIOD_W = 16;
  localparam int AMP_W    = 32;
  localparam int ENERGY_W = 40;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Job queue between front and back; the depth is a power of two.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  // Item command codes.
  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_WRITE  = 1'b1
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PEDESTAL     = 3'd0,
    REG_ADC_GAIN     = 3'd1,
    REG_MV_TO_ENERGY = 3'd2,
    REG_TOT_SCALE    = 3'd3,
    REG_CLOCK_PERIOD = 3'd4
  } cfg_reg_t;

  // One finished hit, handed from the front to the back.
  typedef struct packed {
    logic [ID_W-1:0]     hit_id;
    logic                mode;
    logic [TOT_W-1:0]    tot;
    logic [TOA_W-1:0]    toa;
    logic [VOLT_W-1:0]   max_mv;
    logic [FACTOR_W-1:0] factor;
  } job_t;

  // Queue fill status.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Settings used by the back end.
  typedef struct packed {
    logic [SCALE_W-1:0]  mv_to_energy;
    logic [SCALE_W-1:0]  tot_energy_scale;
    logic [PERIOD_W-1:0] clock_period_ps;
  } back_cfg_t;

endpackage

FILE: rtl/crec_ram.sv
// ----------------------------------------------------------------------------
// crec_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module crec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; data holds while the read is not enabled.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/crec_front.sv
// ----------------------------------------------------------------------------
// crec_front
// Accepts items, loads the layer factor table, tracks the running maximum
// voltage of a hit and pushes one job per finished hit into the queue.
// ----------------------------------------------------------------------------
module crec_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                command,
  input  logic [crec_pkg::ID_W-1:0]           hit_id,
  input  logic [crec_pkg::LAYER_W-1:0]        layer,
  input  logic                                tot_mode,
  input  logic [crec_pkg::ADC_W-1:0]          adc_count,
  input  logic [crec_pkg::TOT_W-1:0]          tot_count,
  input  logic [crec_pkg::TOA_W-1:0]          toa_count,
  input  logic                                last_sample,
  input  logic [crec_pkg::FACTOR_W-1:0]       factor_value,
  input  logic [crec_pkg::ADC_W-1:0]          pedestal,
  input  logic [crec_pkg::GAIN_W-1:0]         adc_gain,
  input  crec_pkg::q_stat_t                   q_stat,
  output logic                                push,
  output crec_pkg::job_t                      job
);

  localparam int PROD_W = crec_pkg::ADC_W + crec_pkg::GAIN_W;

  logic accept;
  logic is_write;
  logic layer_ok;
  logic [crec_pkg::ADC_W-1:0]  diff;
  logic [PROD_W-1:0]           volt_prod;
  logic [crec_pkg::VOLT_W-1:0] volt;
  logic [crec_pkg::FACTOR_W-1:0] factor_rd;

  // Sample stage registers.
  logic                          s1_valid;
  logic                          s1_cmd;
  logic                          s1_last;
  logic                          s1_layer_ok;
  logic                          s1_mode;
  logic [crec_pkg::ID_W-1:0]     s1_hit_id;
  logic [crec_pkg::TOT_W-1:0]    s1_tot;
  logic [crec_pkg::TOA_W-1:0]    s1_toa;
  logic [crec_pkg::VOLT_W-1:0]   s1_volt;
  logic                          s1_job;
  logic                          s1_adv;

  // Hit state.
  logic                          in_hit;
  logic                          cap_mode;
  logic [crec_pkg::TOT_W-1:0]    cap_tot;
  logic [crec_pkg::TOA_W-1:0]    cap_toa;
  logic [crec_pkg::VOLT_W-1:0]   run_max;
  logic [crec_pkg::VOLT_W-1:0]   run_max_next;

  // Handshake: the sample stage moves on unless a job waits for a full queue.
  assign s1_job   = s1_valid && !s1_cmd && s1_last;
  assign s1_adv   = s1_valid && (!s1_job || !q_stat.full);
  assign in_ready = !s1_valid || s1_adv;
  assign accept   = in_valid && in_ready;
  assign is_write = (command == crec_pkg::CMD_WRITE);
  assign layer_ok = int'(layer) < crec_pkg::NUM_LAYERS;

  // Pedestal-subtracted, gain-scaled voltage, saturating at the top of 24 bits.
  assign diff      = adc_count - pedestal;
  assign volt_prod = {{(PROD_W - crec_pkg::ADC_W){1'b0}}, diff}
                   * {{(PROD_W - crec_pkg::GAIN_W){1'b0}}, adc_gain};
  always_comb begin
    if (adc_count <= pedestal) begin
      volt = '0;
    end else if (|volt_prod[PROD_W-1:crec_pkg::VOLT_W]) begin
      volt = '1;
    end else begin
      volt = volt_prod[crec_pkg::VOLT_W-1:0];
    end
  end

  // Layer factor table: written by command items, read for every sample so
  // that the factor in use is the one present when the last sample arrived.
  crec_ram #(
    .WIDTH(crec_pkg::FACTOR_W),
    .DEPTH(crec_pkg::NUM_LAYERS)
  ) u_factor_ram (
    .clk    (clk),
    .wr_en  (accept && is_write && layer_ok),
    .wr_addr(crec_pkg::LAYER_ADDR_W'(layer)),
    .wr_data(factor_value),
    .rd_en  (accept && !is_write),
    .rd_addr(crec_pkg::LAYER_ADDR_W'(layer)),
    .rd_data(factor_rd)
  );

  // Sample stage valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // Sample stage payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd      <= is_write;
      s1_last     <= last_sample;
      s1_layer_ok <= layer_ok;
      s1_mode     <= tot_mode;
      s1_hit_id   <= hit_id;
      s1_tot      <= tot_count;
      s1_toa      <= toa_count;
      s1_volt     <= volt;
    end
  end

  // A new hit starts its maximum from this sample's voltage.
  assign run_max_next = (!in_hit || (s1_volt > run_max)) ? s1_volt : run_max;

  // Hit state update; the first sample captures mode, TOT and TOA.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_hit   <= 1'b0;
      run_max  <= '0;
      cap_mode <= 1'b0;
      cap_tot  <= '0;
      cap_toa  <= '0;
    end else if (s1_adv && !s1_cmd) begin
      in_hit  <= !s1_last;
      run_max <= s1_last ? '0 : run_max_next;
      if (!in_hit) begin
        cap_mode <= s1_mode;
        cap_tot  <= s1_tot;
        cap_toa  <= s1_toa;
      end
    end
  end

  // Job for a finished hit; a single-sample hit uses its own fields.
  assign push = s1_adv && s1_job;
  always_comb begin
    job.hit_id = s1_hit_id;
    job.mode   = in_hit ? cap_mode : s1_mode;
    job.tot    = in_hit ? cap_tot  : s1_tot;
    job.toa    = in_hit ? cap_toa  : s1_toa;
    job.max_mv = run_max_next;
    job.factor = s1_layer_ok ? factor_rd : '0;
  end

endmodule

FILE: rtl/crec_queue.sv
// ----------------------------------------------------------------------------
// crec_queue
// Short job queue that decouples the sample front end from the arithmetic
// back end.
// ----------------------------------------------------------------------------
module crec_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  crec_pkg::job_t    push_job,
  input  logic              pop,
  output crec_pkg::job_t    pop_job,
  output crec_pkg::q_stat_t q_stat
);

  crec_pkg::job_t mem [crec_pkg::QUEUE_DEPTH];
  logic [crec_pkg::QPTR_W-1:0] wr_ptr;
  logic [crec_pkg::QPTR_W-1:0] rd_ptr;
  logic [crec_pkg::QPTR_W:0]   count;

  assign q_stat.full  = (count == (crec_pkg::QPTR_W + 1)'(crec_pkg::QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);
  assign pop_job      = mem[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/crec_back.sv
// ----------------------------------------------------------------------------
// crec_back
// Turns queued jobs into results: amplitude and hit time in one stage, the
// layer-weighted energy in the output stage.
// ----------------------------------------------------------------------------
module crec_back (
  input  logic                          clk,
  input  logic                          rst,
  input  crec_pkg::q_stat_t             q_stat,
  input  crec_pkg::job_t                job,
  output logic                          pop,
  input  crec_pkg::back_cfg_t           cfg,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [crec_pkg::ID_W-1:0]     out_hit_id,
  output logic [crec_pkg::AMP_W-1:0]    amplitude,
  output logic [crec_pkg::ENERGY_W-1:0] energy,
  output logic [crec_pkg::PERIOD_W-1:0] hit_time_ps
);

  localparam int MUL_W  = crec_pkg::VOLT_W;
  localparam int PROD_W = 2 * MUL_W;
  localparam int TIME_W = crec_pkg::TOA_W + crec_pkg::PERIOD_W;
  localparam int EN_W   = crec_pkg::AMP_W + crec_pkg::FACTOR_W;

  logic                          out_adv;
  logic                          b1_ready;
  logic [MUL_W-1:0]              mul_a;
  logic [MUL_W-1:0]              mul_b;
  logic [PROD_W-1:0]             amp_prod;
  logic [crec_pkg::AMP_W-1:0]    amp;
  logic [TIME_W-1:0]             time_prod;
  logic [EN_W-1:0]               energy_prod;

  logic                          b1_valid;
  logic [crec_pkg::ID_W-1:0]     b1_hit_id;
  logic [crec_pkg::AMP_W-1:0]    b1_amp;
  logic [crec_pkg::FACTOR_W-1:0] b1_factor;
  logic [crec_pkg::PERIOD_W-1:0] b1_time;

  // Stall chain from the output register back to the queue.
  assign out_adv  = !out_valid || out_ready;
  assign b1_ready = !b1_valid || out_adv;
  assign pop      = !q_stat.empty && b1_ready;

  // One multiplier serves both modes. TOT mode scales count/4096; ADC mode
  // scales the Q16.8 maximum by a Q0.24 factor. Neither can pass 32 bits.
  assign mul_a    = job.mode ? MUL_W'(job.tot) : job.max_mv;
  assign mul_b    = job.mode ? cfg.tot_energy_scale : cfg.mv_to_energy;
  assign amp_prod = {{MUL_W{1'b0}}, mul_a} * {{MUL_W{1'b0}}, mul_b};
  assign amp      = job.mode ? crec_pkg::AMP_W'(amp_prod >> 12)
                             : amp_prod[16 +: crec_pkg::AMP_W];

  // Hit time: toa periods in units of 1/1024.
  assign time_prod = {{crec_pkg::PERIOD_W{1'b0}}, job.toa}
                   * {{crec_pkg::TOA_W{1'b0}}, cfg.clock_period_ps};

  // Amplitude stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
    end else if (b1_ready) begin
      b1_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b1_hit_id <= job.hit_id;
      b1_amp    <= amp;
      b1_factor <= job.factor;
      b1_time   <= time_prod[10 +: crec_pkg::PERIOD_W];
    end
  end

  // Energy: a 32 by 24 bit product shifted down by 16 fits 40 bits exactly.
  assign energy_prod = {{crec_pkg::FACTOR_W{1'b0}}, b1_amp}
                     * {{crec_pkg::AMP_W{1'b0}}, b1_factor};

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= b1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && b1_valid) begin
      out_hit_id  <= b1_hit_id;
      amplitude   <= b1_amp;
      energy      <= energy_prod[16 +: crec_pkg::ENERGY_W];
      hit_time_ps <= b1_time;
    end
  end

endmodule

FILE: rtl/calorimeter_hit_energy_reco.sv
// ----------------------------------------------------------------------------
// calorimeter_hit_energy_reco
// Path: sample stage register, job queue, amplitude stage, output register.
// Throughput: one item per cycle unless a finished hit waits on a full job
// queue; the four-entry job queue and the output register let the front
// take samples while results wait.
// Reset clears all control and hit state and loads the register defaults;
// the layer factor table is undefined until written by command items.
// ----------------------------------------------------------------------------
module calorimeter_hit_energy_reco (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration write channel.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [crec_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [crec_pkg::CFG_DATA_W-1:0] cfg_data,
  // Input items.
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            command,
  input  logic [crec_pkg::ID_W-1:0]       hit_id,
  input  logic [crec_pkg::LAYER_W-1:0]    layer,
  input  logic                            tot_mode,
  input  logic [crec_pkg::ADC_W-1:0]      adc_count,
  input  logic [crec_pkg::TOT_W-1:0]      tot_count,
  input  logic [crec_pkg::TOA_W-1:0]      toa_count,
  input  logic                            last_sample,
  input  logic [crec_pkg::FACTOR_W-1:0]   factor_value,
  // Result items.
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [crec_pkg::ID_W-1:0]       out_hit_id,
  output logic [crec_pkg::AMP_W-1:0]      amplitude,
  output logic [crec_pkg::ENERGY_W-1:0]   energy,
  output logic [crec_pkg::PERIOD_W-1:0]   hit_time_ps
);

  logic [crec_pkg::ADC_W-1:0]    pedestal;
  logic [crec_pkg::GAIN_W-1:0]   adc_gain;
  crec_pkg::back_cfg_t           back_cfg;

  logic                          q_push;
  logic                          q_pop;
  crec_pkg::job_t                push_job;
  crec_pkg::job_t                pop_job;
  crec_pkg::q_stat_t             q_stat;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pedestal                  <= '0;
      adc_gain                  <= crec_pkg::GAIN_W'(256);
      back_cfg.mv_to_energy     <= '0;
      back_cfg.tot_energy_scale <= '0;
      back_cfg.clock_period_ps  <= crec_pkg::PERIOD_W'(25000);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        crec_pkg::REG_PEDESTAL:     pedestal <= cfg_data[crec_pkg::ADC_W-1:0];
        crec_pkg::REG_ADC_GAIN:     adc_gain <= cfg_data[crec_pkg::GAIN_W-1:0];
        crec_pkg::REG_MV_TO_ENERGY: back_cfg.mv_to_energy <= cfg_data;
        crec_pkg::REG_TOT_SCALE:    back_cfg.tot_energy_scale <= cfg_data;
        crec_pkg::REG_CLOCK_PERIOD: begin
          back_cfg.clock_period_ps <= cfg_data[crec_pkg::PERIOD_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Front end: sample handling and table loads.
  crec_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .hit_id      (hit_id),
    .layer       (layer),
    .tot_mode    (tot_mode),
    .adc_count   (adc_count),
    .tot_count   (tot_count),
    .toa_count   (toa_count),
    .last_sample (last_sample),
    .factor_value(factor_value),
    .pedestal    (pedestal),
    .adc_gain    (adc_gain),
    .q_stat      (q_stat),
    .push        (q_push),
    .job         (push_job)
  );

  // Job queue.
  crec_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_job(push_job),
    .pop     (q_pop),
    .pop_job (pop_job),
    .q_stat  (q_stat)
  );

  // Back end: amplitude, time and energy.
  crec_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_stat     (q_stat),
    .job        (pop_job),
    .pop        (q_pop),
    .cfg        (back_cfg),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_hit_id (out_hit_id),
    .amplitude  (amplitude),
    .energy     (energy),
    .hit_time_ps(hit_time_ps)
  );

  // The front never pushes a job into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("job pushed into a full queue");

  // The back never pops an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("job popped from an empty queue");

  // A push into an empty queue with no pop leaves it non-empty.
  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    (q_push && !q_pop) |=> !q_stat.empty)
    else $error("queue empty after a push");

  // No result is offered right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule
